// ===== rtl/efsb_pkg.sv =====
package efsb_pkg;

    // Canvas limit: a larger canvas dimension is clamped to this
    localparam int MAX_CANVAS = 4096;

    // Field widths
    localparam int PIX_W   = 12;            // pixel column / row
    localparam int COORD_W = 14;            // signed ellipse center
    localparam int RAD_W   = 12;            // radii and stroke width
    localparam int DIM_W   = 16;            // canvas dimension field
    localparam int SQ_W    = 2 * RAD_W;     // square of a radius or offset
    localparam int PROD_W  = 2 * SQ_W;      // product of two squares
    localparam int CH_W    = 8;             // one color channel
    localparam int SUM_W   = 2 * CH_W;      // blend numerator

    // x / 255 == (x * 32897) >> 23 for every 16-bit x
    localparam int DIV_MUL_W = 17;
    localparam int DIV_PROD_W = SUM_W + DIV_MUL_W;
    localparam logic [DIV_MUL_W-1:0] DIV255_MUL = 17'd32897;
    localparam int DIV255_SHIFT = 23;

    localparam logic [CH_W-1:0] ALPHA_FULL = 8'hFF;

    // APB register map, one 32-bit word per register
    localparam int ADDR_W = 5;
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_X     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_Y     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RADIUS_X     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RADIUS_Y     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_STROKE_WIDTH = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_FILL_COLOR   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_STROKE_COLOR = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_CANVAS_SIZE  = 3'd7;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // Input beat
    typedef struct packed {
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
        logic [31:0]      dst_pixel;
    } t_pix_in;

    // Output beat
    typedef struct packed {
        logic [31:0] new_pixel;
        logic        written;
    } t_pix_out;

    // Classified pixel handed from front to back
    typedef struct packed {
        logic [SQ_W-1:0] dx2;
        logic [SQ_W-1:0] dy2;
        logic            near;      // on canvas, drawing on, inside bounding box
        logic [31:0]     dst;
    } t_item;

    // Configuration and values derived from it
    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic [RAD_W-1:0]  radius_x;
        logic [RAD_W-1:0]  radius_y;
        logic [DIM_W-1:0]  canvas_w;    // clamped
        logic [DIM_W-1:0]  canvas_h;    // clamped
        logic [31:0]       fill_color;
        logic [31:0]       stroke_color;
        logic [SQ_W-1:0]   rx2;
        logic [SQ_W-1:0]   ry2;
        logic [SQ_W-1:0]   irx2;
        logic [SQ_W-1:0]   iry2;
        logic [PROD_W-1:0] rxy2;
        logic [PROD_W-1:0] irxy2;
        logic              draw_en;     // both radii nonzero
        logic              stroke_en;   // stroke width and stroke alpha nonzero
        logic              inner_zero;  // an inner radius is zero
    } t_cfg;

endpackage

// ===== rtl/efsb_cfg.sv =====
module efsb_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [efsb_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output efsb_pkg::t_cfg               o_cfg
);
    import efsb_pkg::*;

    logic signed [COORD_W-1:0] r_center_x;
    logic signed [COORD_W-1:0] r_center_y;
    logic [RAD_W-1:0] r_radius_x;
    logic [RAD_W-1:0] r_radius_y;
    logic [RAD_W-1:0] r_stroke_width;
    logic [31:0]      r_fill_color;
    logic [31:0]      r_stroke_color;
    logic [31:0]      r_canvas_size;

    logic [RAD_W-1:0]  r_irx;
    logic [RAD_W-1:0]  r_iry;
    logic              r_inner_zero;
    logic              r_stroke_en;
    logic [SQ_W-1:0]   r_rx2;
    logic [SQ_W-1:0]   r_ry2;
    logic [SQ_W-1:0]   r_irx2;
    logic [SQ_W-1:0]   r_iry2;
    logic [PROD_W-1:0] r_rxy2;
    logic [PROD_W-1:0] r_irxy2;

    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;
    logic [RAD_W-1:0]     n_irx;
    logic [RAD_W-1:0]     n_iry;
    logic [DIM_W-1:0]     cw_raw;
    logic [DIM_W-1:0]     ch_raw;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x     <= '0;
            r_center_y     <= '0;
            r_radius_x     <= '0;
            r_radius_y     <= '0;
            r_stroke_width <= '0;
            r_fill_color   <= '0;
            r_stroke_color <= '0;
            r_canvas_size  <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_CENTER_X:     r_center_x     <= pwdata[COORD_W-1:0];
                REG_CENTER_Y:     r_center_y     <= pwdata[COORD_W-1:0];
                REG_RADIUS_X:     r_radius_x     <= pwdata[RAD_W-1:0];
                REG_RADIUS_Y:     r_radius_y     <= pwdata[RAD_W-1:0];
                REG_STROKE_WIDTH: r_stroke_width <= pwdata[RAD_W-1:0];
                REG_FILL_COLOR:   r_fill_color   <= pwdata;
                REG_STROKE_COLOR: r_stroke_color <= pwdata;
                REG_CANVAS_SIZE:  r_canvas_size  <= pwdata;
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (reg_idx)
            REG_CENTER_X:     prdata = {{(32-COORD_W){1'b0}}, r_center_x};
            REG_CENTER_Y:     prdata = {{(32-COORD_W){1'b0}}, r_center_y};
            REG_RADIUS_X:     prdata = {{(32-RAD_W){1'b0}}, r_radius_x};
            REG_RADIUS_Y:     prdata = {{(32-RAD_W){1'b0}}, r_radius_y};
            REG_STROKE_WIDTH: prdata = {{(32-RAD_W){1'b0}}, r_stroke_width};
            REG_FILL_COLOR:   prdata = r_fill_color;
            REG_STROKE_COLOR: prdata = r_stroke_color;
            REG_CANVAS_SIZE:  prdata = r_canvas_size;
            default:          prdata = '0;
        endcase
    end

    // Inner radii, saturating at zero
    assign n_irx = (r_radius_x > r_stroke_width) ? r_radius_x - r_stroke_width : '0;
    assign n_iry = (r_radius_y > r_stroke_width) ? r_radius_y - r_stroke_width : '0;

    // Derived terms, free running; inner radii, then their squares, then the products of squares are registered in turn
    always_ff @(posedge i_clk) begin
        r_irx        <= n_irx;
        r_iry        <= n_iry;
        r_inner_zero <= (n_irx == '0) || (n_iry == '0);
        r_stroke_en  <= (r_stroke_width != '0) && (r_stroke_color[31:24] != '0);
        r_rx2        <= r_radius_x * r_radius_x;
        r_ry2        <= r_radius_y * r_radius_y;
        r_irx2       <= r_irx * r_irx;
        r_iry2       <= r_iry * r_iry;
        r_rxy2       <= r_rx2 * r_ry2;
        r_irxy2      <= r_irx2 * r_iry2;
    end

    // Canvas clamp
    assign cw_raw = r_canvas_size[DIM_W-1:0];
    assign ch_raw = r_canvas_size[2*DIM_W-1:DIM_W];

    always_comb begin
        o_cfg.center_x     = r_center_x;
        o_cfg.center_y     = r_center_y;
        o_cfg.radius_x     = r_radius_x;
        o_cfg.radius_y     = r_radius_y;
        o_cfg.canvas_w     = (cw_raw > DIM_W'(MAX_CANVAS)) ? DIM_W'(MAX_CANVAS) : cw_raw;
        o_cfg.canvas_h     = (ch_raw > DIM_W'(MAX_CANVAS)) ? DIM_W'(MAX_CANVAS) : ch_raw;
        o_cfg.fill_color   = r_fill_color;
        o_cfg.stroke_color = r_stroke_color;
        o_cfg.rx2          = r_rx2;
        o_cfg.ry2          = r_ry2;
        o_cfg.irx2         = r_irx2;
        o_cfg.iry2         = r_iry2;
        o_cfg.rxy2         = r_rxy2;
        o_cfg.irxy2        = r_irxy2;
        o_cfg.draw_en      = (r_radius_x != '0) && (r_radius_y != '0);
        o_cfg.stroke_en    = r_stroke_en;
        o_cfg.inner_zero   = r_inner_zero;
    end

endmodule

// ===== rtl/efsb_front.sv =====
module efsb_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  efsb_pkg::t_cfg    i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  efsb_pkg::t_pix_in i_data,
    output logic              o_push,
    input  logic              i_full,
    output efsb_pkg::t_item   o_item
);
    import efsb_pkg::*;

    localparam int DIFF_W = COORD_W + 1;

    // Stage 1: offsets and bounding-box classification
    logic              r_f1_valid;
    logic [RAD_W-1:0]  r_f1_adx;
    logic [RAD_W-1:0]  r_f1_ady;
    logic              r_f1_near;
    logic [31:0]       r_f1_dst;

    // Stage 2: squared offsets
    logic              r_f2_valid;
    t_item             r_f2_item;

    logic                     f1_adv;
    logic                     f2_adv;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic [DIFF_W-1:0]        adx;
    logic [DIFF_W-1:0]        ady;
    logic                     on_canvas;
    logic                     n_f1_near;
    t_item                    n_f2_item;

    assign f2_adv  = !r_f2_valid || !i_full;
    assign f1_adv  = !r_f1_valid || f2_adv;
    assign o_ready = f1_adv;
    assign o_push  = r_f2_valid && !i_full;
    assign o_item  = r_f2_item;

    // Offsets from the center and their magnitudes
    always_comb begin
        dx  = $signed({{(DIFF_W-PIX_W){1'b0}}, i_data.pixel_x})
            - $signed({i_cfg.center_x[COORD_W-1], i_cfg.center_x});
        dy  = $signed({{(DIFF_W-PIX_W){1'b0}}, i_data.pixel_y})
            - $signed({i_cfg.center_y[COORD_W-1], i_cfg.center_y});
        adx = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
        ady = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
        on_canvas = ({{(DIM_W-PIX_W){1'b0}}, i_data.pixel_x} < i_cfg.canvas_w)
                 && ({{(DIM_W-PIX_W){1'b0}}, i_data.pixel_y} < i_cfg.canvas_h);
        // beyond a radius the pixel is outside; squares then fit the narrow path
        n_f1_near = i_cfg.draw_en && on_canvas
                 && (adx <= {{(DIFF_W-RAD_W){1'b0}}, i_cfg.radius_x})
                 && (ady <= {{(DIFF_W-RAD_W){1'b0}}, i_cfg.radius_y});
    end

    always_comb begin
        n_f2_item.dx2  = r_f1_adx * r_f1_adx;
        n_f2_item.dy2  = r_f1_ady * r_f1_ady;
        n_f2_item.near = r_f1_near;
        n_f2_item.dst  = r_f1_dst;
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
        end else begin
            if (f1_adv) begin
                r_f1_valid <= i_valid;
            end
            if (f2_adv) begin
                r_f2_valid <= r_f1_valid;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (f1_adv) begin
            r_f1_adx  <= adx[RAD_W-1:0];
            r_f1_ady  <= ady[RAD_W-1:0];
            r_f1_near <= n_f1_near;
            r_f1_dst  <= i_data.dst_pixel;
        end
        if (f2_adv) begin
            r_f2_item <= n_f2_item;
        end
    end

endmodule

// ===== rtl/efsb_queue.sv =====
module efsb_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  efsb_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output efsb_pkg::t_item o_item
);
    import efsb_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== rtl/efsb_back.sv =====
module efsb_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  efsb_pkg::t_cfg     i_cfg,
    input  logic               i_q_valid,
    input  efsb_pkg::t_item    i_q_item,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output efsb_pkg::t_pix_out o_data
);
    import efsb_pkg::*;

    localparam int CMP_W = PROD_W + 1;

    // Stage 1: cross products of squares
    logic              r_b1_valid;
    logic [PROD_W-1:0] r_b1_dx_ry;
    logic [PROD_W-1:0] r_b1_dy_rx;
    logic [PROD_W-1:0] r_b1_dx_iry;
    logic [PROD_W-1:0] r_b1_dy_irx;
    logic              r_b1_near;
    logic [31:0]       r_b1_dst;

    // Stage 2: coverage decision and color choice
    logic        r_b2_valid;
    logic        r_b2_wr;
    logic [31:0] r_b2_src;
    logic [31:0] r_b2_dst;

    // Stage 3: blend numerators
    logic             r_b3_valid;
    logic             r_b3_wr;
    logic             r_b3_full;
    logic [23:0]      r_b3_src_rgb;
    logic [31:0]      r_b3_dst;
    logic [SUM_W-1:0] r_b3_sum [4];

    // Stage 4: output register
    logic     r_b4_valid;
    t_pix_out r_b4_data;

    logic b1_adv;
    logic b2_adv;
    logic b3_adv;
    logic b4_adv;

    logic             covered;
    logic             in_inner;
    logic             is_stroke;
    logic             n_b2_wr;
    logic [31:0]      n_b2_src;
    logic [CH_W-1:0]  alpha;
    logic [CH_W-1:0]  inv_alpha;
    logic [SUM_W-1:0] n_b3_sum [4];
    logic [DIV_PROD_W-1:0] quot_prod [4];
    logic [CH_W-1:0]  quot [4];
    t_pix_out         n_b4_data;

    assign b4_adv  = !r_b4_valid || i_ready;
    assign b3_adv  = !r_b3_valid || b4_adv;
    assign b2_adv  = !r_b2_valid || b3_adv;
    assign b1_adv  = !r_b1_valid || b2_adv;
    assign o_pop   = i_q_valid && b1_adv;
    assign o_valid = r_b4_valid;
    assign o_data  = r_b4_data;

    // Outer and inner ellipse tests, then pick stroke or fill
    always_comb begin
        covered   = r_b1_near
                 && (({1'b0, r_b1_dx_ry} + {1'b0, r_b1_dy_rx}) <= CMP_W'(i_cfg.rxy2));
        in_inner  = ({1'b0, r_b1_dx_iry} + {1'b0, r_b1_dy_irx}) <= CMP_W'(i_cfg.irxy2);
        is_stroke = i_cfg.stroke_en && (i_cfg.inner_zero || !in_inner);
        n_b2_src  = is_stroke ? i_cfg.stroke_color : i_cfg.fill_color;
        n_b2_wr   = covered && (is_stroke || (i_cfg.fill_color[31:24] != '0));
    end

    // Numerators: s*a + d*(255-a) per channel, a*(255-da) for alpha
    always_comb begin
        alpha     = r_b2_src[31:24];
        inv_alpha = ALPHA_FULL - alpha;
        for (int i = 0; i < 3; i++) begin
            n_b3_sum[i] = SUM_W'(r_b2_src[CH_W*i +: CH_W]) * SUM_W'(alpha)
                        + SUM_W'(r_b2_dst[CH_W*i +: CH_W]) * SUM_W'(inv_alpha);
        end
        n_b3_sum[3] = SUM_W'(alpha) * SUM_W'(ALPHA_FULL - r_b2_dst[31:24]);
    end

    // Divide by 255 through a reciprocal multiply, then assemble the pixel
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            quot_prod[i] = DIV_PROD_W'(r_b3_sum[i]) * DIV_PROD_W'(DIV255_MUL);
            quot[i]      = quot_prod[i][DIV255_SHIFT +: CH_W];
        end
        n_b4_data.written = r_b3_wr;
        if (!r_b3_wr) begin
            n_b4_data.new_pixel = r_b3_dst;
        end else if (r_b3_full) begin
            n_b4_data.new_pixel = {ALPHA_FULL, r_b3_src_rgb};
        end else begin
            // da + a*(255-da)/255 never exceeds 255
            n_b4_data.new_pixel = {r_b3_dst[31:24] + quot[3], quot[2], quot[1], quot[0]};
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
            r_b2_valid <= 1'b0;
            r_b3_valid <= 1'b0;
            r_b4_valid <= 1'b0;
        end else begin
            if (b1_adv) begin
                r_b1_valid <= i_q_valid;
            end
            if (b2_adv) begin
                r_b2_valid <= r_b1_valid;
            end
            if (b3_adv) begin
                r_b3_valid <= r_b2_valid;
            end
            if (b4_adv) begin
                r_b4_valid <= r_b3_valid;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (b1_adv) begin
            r_b1_dx_ry  <= i_q_item.dx2 * i_cfg.ry2;
            r_b1_dy_rx  <= i_q_item.dy2 * i_cfg.rx2;
            r_b1_dx_iry <= i_q_item.dx2 * i_cfg.iry2;
            r_b1_dy_irx <= i_q_item.dy2 * i_cfg.irx2;
            r_b1_near   <= i_q_item.near;
            r_b1_dst    <= i_q_item.dst;
        end
        if (b2_adv) begin
            r_b2_wr  <= n_b2_wr;
            r_b2_src <= n_b2_src;
            r_b2_dst <= r_b1_dst;
        end
        if (b3_adv) begin
            r_b3_wr      <= r_b2_wr;
            r_b3_full    <= (alpha == ALPHA_FULL);
            r_b3_src_rgb <= r_b2_src[23:0];
            r_b3_dst     <= r_b2_dst;
            for (int i = 0; i < 4; i++) begin
                r_b3_sum[i] <= n_b3_sum[i];
            end
        end
        if (b4_adv) begin
            r_b4_data <= n_b4_data;
        end
    end

endmodule

// ===== rtl/ellipse_fill_stroke_blend.sv =====
// Ellipse fill/stroke with source-over blend. Each input beat carries one canvas
// pixel (column, row, current RGBA) and yields exactly one output beat with the
// new RGBA and a written flag; unwritten pixels come back unchanged. The block
// takes one beat per clock unless a held output has backed up to the input, and
// returns results in order. The path is two front stages (center offsets,
// squares), a four-entry queue, and four back stages (24x24 cross products,
// ellipse compares, blend numerators, divide by 255 into the output register).
// The queue lets the input keep flowing for a few beats while the output
// is held.
// Registers sit at byte addresses 0x00..0x1C in the order center_x, center_y,
// radius_x, radius_y, stroke_width, fill_color, stroke_color, canvas_size; all
// reset to zero. Derived squares are registered in turn after a write and
// settle before a pixel accepted after the write reaches them. Write
// configuration only while no pixels are in flight.
module ellipse_fill_stroke_blend (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [efsb_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  efsb_pkg::t_pix_in            i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output efsb_pkg::t_pix_out           o_out_data
);
    import efsb_pkg::*;

    t_cfg  cfg;
    t_item front_item;
    t_item queue_item;
    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_valid;

    efsb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    efsb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .o_push  (q_push),
        .i_full  (q_full),
        .o_item  (front_item)
    );

    efsb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (queue_item)
    );

    efsb_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_valid (q_valid),
        .i_q_item  (queue_item),
        .o_pop     (q_pop),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_data    (o_out_data)
    );

endmodule
